/* rtl/skf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath types for the scalar Kalman filter.
// No dependencies.
package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = 33;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_MEASURE = 2'd1;
  localparam logic [1:0] ACT_INIT    = 2'd2;
  localparam logic [1:0] ACT_RESET   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNINIT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_NOISE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R_NOISE          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VARIANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_SQ          = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_MUL_AREA, OP_MUL_GROW, OP_SAMPLE_UPD, OP_SAMPLE_PREV,
    OP_DIFF, OP_MUL_SQ, OP_MUL_LIM, OP_MUL_NUM, OP_MUL_VNUM, OP_DIV_INIT,
    OP_DIV_STEP, OP_MEAS_UPD, OP_INIT, OP_RESET
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       load_out;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       initialized;
    logic       have_prev;
    logic       reject;
    logic       s_zero;
  } dp_stat_t;

endpackage

/* rtl/skf_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// No dependencies.
interface skf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] value;
  logic [31:0] sample_time;
  modport source (output valid, action, value, sample_time, input ready);
  modport sink (input valid, action, value, sample_time, output ready);
endinterface

interface skf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] estimate;
  logic [31:0] variance;
  logic [31:0] innovation;
  logic [1:0]  status;
  modport source (output valid, estimate, variance, innovation, status, input ready);
  modport sink (input valid, estimate, variance, innovation, status, output ready);
endinterface

/* rtl/skf_datapath.sv */
`timescale 1ns / 1ps
// Datapath: filter state, configuration, shared multiplier, dual restoring divider.
// Depends on skf_pkg.
module skf_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic [1:0]                      in_action,
  input  logic [31:0]                     in_value,
  input  logic [31:0]                     in_time,
  input  skf_pkg::dp_cmd_t                cmd,
  output skf_pkg::dp_stat_t               stat,
  output logic [31:0]                     out_estimate,
  output logic [31:0]                     out_variance,
  output logic [31:0]                     out_innovation,
  output logic [1:0]                      out_status
);
  import skf_pkg::*;

  localparam int F = FRAC_BITS;

  logic [31:0] q_noise, r_noise, initial_variance;
  logic        gate_enable;
  logic [15:0] gate_sq;

  logic signed [31:0] est;
  logic [31:0]        var_p;
  logic               initialized, have_prev;
  logic signed [31:0] prev_v;
  logic [31:0]        prev_t;

  logic [1:0]         act;
  logic signed [31:0] val;
  logic [31:0]        tim;
  logic signed [31:0] innov;

  logic [63:0] acc1, acc2;
  logic [32:0] rem1, rem2;

  function automatic logic [31:0] sat_s32(input logic signed [65:0] x);
    if (x > 66'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
    else if (x < -66'sh0_8000_0000) return 32'h8000_0000;
    else return x[31:0];
  endfunction

  logic signed [32:0] vsum, ediff;
  logic [32:0] smag, emag, s_sum;
  logic [31:0] dt;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic [63:0] hi;
  logic [63:0] area, grow, vgrow;
  logic signed [65:0] est_samp, est_meas;
  logic [33:0] t1, t2, d_meas, nv;
  logic ge1, ge2, rnd1, rnd2;

  always_comb begin
    vsum  = 33'(prev_v) + 33'(val);
    smag  = vsum[32] ? 33'(-vsum) : 33'(vsum);
    dt    = tim - prev_t;
    ediff = 33'(val) - 33'(est);
    emag  = ediff[32] ? 33'(-ediff) : 33'(ediff);
    s_sum = {1'b0, var_p} + {1'b0, r_noise};
    case (cmd.op)
      OP_MUL_AREA: begin mul_a = smag;              mul_b = {1'b0, dt}; end
      OP_MUL_GROW: begin mul_a = {1'b0, dt};        mul_b = {1'b0, q_noise}; end
      OP_MUL_SQ:   begin mul_a = emag;              mul_b = emag; end
      OP_MUL_LIM:  begin mul_a = {17'd0, gate_sq};  mul_b = s_sum; end
      OP_MUL_NUM:  begin mul_a = {1'b0, var_p};     mul_b = emag; end
      OP_MUL_VNUM: begin mul_a = {1'b0, var_p};     mul_b = {1'b0, r_noise}; end
      default:     begin mul_a = '0;                mul_b = '0; end
    endcase
    prod = 66'(mul_a) * 66'(mul_b);
    hi   = acc1 >> F;
    area = (acc1 >> (F + 1)) + 64'(acc1[F]);
    grow = (acc2 >> F) + 64'(acc2[F-1]);
    vgrow = {32'd0, var_p} + grow;
    est_samp = vsum[32] ? 66'(est) - 66'(area) : 66'(est) + 66'(area);
    t1  = {rem1, acc1[32]};
    t2  = {rem2, acc2[32]};
    ge1 = t1 >= {1'b0, s_sum};
    ge2 = t2 >= {1'b0, s_sum};
    rnd1 = {rem1, 1'b0} >= {1'b0, s_sum};
    rnd2 = {rem2, 1'b0} >= {1'b0, s_sum};
    d_meas = {1'b0, acc1[32:0]} + 34'(rnd1);
    nv     = {1'b0, acc2[32:0]} + 34'(rnd2);
    est_meas = ediff[32] ? 66'(est) - 66'(d_meas) : 66'(est) + 66'(d_meas);
  end

  assign stat.action      = act;
  assign stat.initialized = initialized;
  assign stat.have_prev   = have_prev;
  assign stat.reject      = gate_enable &&
                            ((hi > acc2) || ((hi == acc2) && (acc1[F-1:0] != '0)));
  assign stat.s_zero      = (s_sum == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise          <= '0;
      r_noise          <= 32'(1) << F;
      initial_variance <= 32'(1) << F;
      gate_enable      <= 1'b0;
      gate_sq          <= 16'd25;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_Q_NOISE:          q_noise          <= cfg_data;
        CFG_R_NOISE:          r_noise          <= cfg_data;
        CFG_INITIAL_VARIANCE: initial_variance <= cfg_data;
        CFG_GATE_ENABLE:      gate_enable      <= cfg_data[0];
        CFG_GATE_SQ:          gate_sq          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
      var_p <= '0;
      initialized <= 1'b0;
      have_prev <= 1'b0;
      prev_v <= '0;
      prev_t <= '0;
    end else begin
      case (cmd.op)
        OP_SAMPLE_UPD: begin
          est   <= sat_s32(est_samp);
          var_p <= (vgrow[63:32] != '0) ? 32'hFFFF_FFFF : vgrow[31:0];
        end
        OP_SAMPLE_PREV: begin
          prev_v <= val;
          prev_t <= tim;
          have_prev <= 1'b1;
        end
        OP_MEAS_UPD: begin
          est   <= sat_s32(est_meas);
          var_p <= (nv[33:32] != '0) ? 32'hFFFF_FFFF : nv[31:0];
        end
        OP_INIT: begin
          est <= val;
          var_p <= initial_variance;
          initialized <= 1'b1;
        end
        OP_RESET: begin
          initialized <= 1'b0;
          have_prev <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        act   <= in_action;
        val   <= in_value;
        tim   <= in_time;
        innov <= '0;
      end
      OP_DIFF: innov <= sat_s32(66'(ediff));
      OP_MUL_AREA, OP_MUL_SQ, OP_MUL_NUM: acc1 <= prod[63:0];
      OP_MUL_GROW, OP_MUL_LIM, OP_MUL_VNUM: acc2 <= prod[63:0];
      OP_DIV_INIT: begin
        rem1 <= {2'b00, acc1[63:33]};
        rem2 <= {2'b00, acc2[63:33]};
      end
      OP_DIV_STEP: begin
        rem1 <= ge1 ? 33'(t1 - {1'b0, s_sum}) : t1[32:0];
        rem2 <= ge2 ? 33'(t2 - {1'b0, s_sum}) : t2[32:0];
        acc1[32:0] <= {acc1[31:0], ge1};
        acc2[32:0] <= {acc2[31:0], ge2};
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      out_estimate   <= est;
      out_variance   <= var_p;
      out_innovation <= innov;
      out_status     <= cmd.status;
    end
  end

endmodule

/* rtl/skf_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences the datapath and owns the handshakes.
// Depends on skf_pkg.
module skf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  skf_pkg::dp_stat_t stat,
  output skf_pkg::dp_cmd_t  cmd
);
  import skf_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001, S_DECODE   = 16'h0002, S_MUL_AREA = 16'h0004,
    S_MUL_GROW = 16'h0008, S_SUPD     = 16'h0010, S_SPREV    = 16'h0020,
    S_DIFF     = 16'h0040, S_MUL_SQ   = 16'h0080, S_MUL_LIM  = 16'h0100,
    S_GATE     = 16'h0200, S_MUL_NUM  = 16'h0400, S_MUL_VNUM = 16'h0800,
    S_DIV_INIT = 16'h1000, S_DIV      = 16'h2000, S_MUPD     = 16'h4000,
    S_OUT      = 16'h8000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0] status, status_next;
  logic out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    status_next = status;
    out_valid_next = out_valid && !out_ready;
    cmd.op = OP_NONE;
    cmd.load_out = 1'b0;
    cmd.status = status;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LATCH;
          status_next = ST_OK;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.action)
          ACT_SAMPLE: begin
            status_next = stat.initialized ? ST_OK : ST_UNINIT;
            state_next = (stat.initialized && stat.have_prev) ? S_MUL_AREA : S_SPREV;
          end
          ACT_MEASURE: begin
            if (stat.initialized) begin
              state_next = S_DIFF;
            end else begin
              status_next = ST_UNINIT;
              state_next = S_OUT;
            end
          end
          ACT_INIT: begin
            cmd.op = OP_INIT;
            state_next = S_OUT;
          end
          default: begin
            cmd.op = OP_RESET;
            state_next = S_OUT;
          end
        endcase
      end
      S_MUL_AREA: begin cmd.op = OP_MUL_AREA;    state_next = S_MUL_GROW; end
      S_MUL_GROW: begin cmd.op = OP_MUL_GROW;    state_next = S_SUPD; end
      S_SUPD:     begin cmd.op = OP_SAMPLE_UPD;  state_next = S_SPREV; end
      S_SPREV:    begin cmd.op = OP_SAMPLE_PREV; state_next = S_OUT; end
      S_DIFF:     begin cmd.op = OP_DIFF;        state_next = S_MUL_SQ; end
      S_MUL_SQ:   begin cmd.op = OP_MUL_SQ;      state_next = S_MUL_LIM; end
      S_MUL_LIM:  begin cmd.op = OP_MUL_LIM;     state_next = S_GATE; end
      S_GATE: begin
        if (stat.reject) begin
          status_next = ST_REJECT;
          state_next = S_OUT;
        end else if (stat.s_zero) begin
          state_next = S_OUT;
        end else begin
          state_next = S_MUL_NUM;
        end
      end
      S_MUL_NUM:  begin cmd.op = OP_MUL_NUM;     state_next = S_MUL_VNUM; end
      S_MUL_VNUM: begin cmd.op = OP_MUL_VNUM;    state_next = S_DIV_INIT; end
      S_DIV_INIT: begin
        cmd.op = OP_DIV_INIT;
        count_next = CNT_W'(DIV_STEPS - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        count_next = count - 1'b1;
        if (count == '0) state_next = S_MUPD;
      end
      S_MUPD: begin cmd.op = OP_MEAS_UPD; state_next = S_OUT; end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      status <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      status <= status_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/scalar_kalman_filter_with_gate.sv */
`timescale 1ns / 1ps
// Top level of the scalar Kalman filter with innovation gating.
// Depends on skf_pkg, skf_ifs (channel interfaces), skf_ctrl and skf_datapath.
//
//   Channel   Direction  Beat contents
//   in_ch     sink       action, value, sample_time
//   out_ch    source     estimate, variance, innovation, status
//   cfg_*     write      cfg_index selects the register, cfg_data holds it
//
// One item is worked at a time. An applied measurement runs through the 33-step
// restoring divider that forms the gain and the new variance in parallel.
// Reset is synchronous and loads the register defaults and clears the filter state.
// The result register lets the next beat be accepted while a result waits; a
// stalled output holds the block only when a second result is ready to be written.
module scalar_kalman_filter_with_gate (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  skf_in_if.sink                        in_ch,
  skf_out_if.source                     out_ch
);
  import skf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller decides the order of operations; the datapath only reacts
  // to the command of the current cycle.
  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the filter state and configuration, and the result register.
  skf_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_action      (in_ch.action),
    .in_value       (in_ch.value),
    .in_time        (in_ch.sample_time),
    .cmd            (cmd),
    .stat           (stat),
    .out_estimate   (out_ch.estimate),
    .out_variance   (out_ch.variance),
    .out_innovation (out_ch.innovation),
    .out_status     (out_ch.status)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for scalar_kalman_filter_with_gate.
// Depends on skf_pkg, the skf_in_if/skf_out_if channel interfaces and the filter RTL.
module tb;
  import skf_pkg::*;

  localparam int STALL_LIMIT = 6000;
  localparam int SETTLE      = 80;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic [31:0] est;
    logic [31:0] varc;
    logic [31:0] innov;
    logic [1:0]  status;
  } filt_out_t;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] value;
    logic [31:0] stamp;
    bit          typed;
    filt_out_t   res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  skf_in_if  in_ch();
  skf_out_if out_ch();

  scalar_kalman_filter_with_gate u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  // Filter model state and its copy of the registers.
  logic [31:0]        m_pnoise, m_mnoise, m_init_var;
  logic               m_gate_on;
  logic [15:0]        m_gate_sq;
  logic signed [31:0] m_est;
  logic [31:0]        m_var;
  logic               m_ready_init, m_have_prev;
  logic signed [31:0] m_prev_vel;
  logic [31:0]        m_prev_time;

  filt_out_t pending_results[$];
  int        errors = 0;
  int        src_idle = 0;
  int        snk_idle = 0;
  int        quiet_cycles = 0;
  bit        typed_beat = 1'b0;
  filt_out_t typed_res = '0;

  function automatic logic [31:0] clamp_s32(longint v);
    if (v > longint'(32'sh7fffffff)) return 32'h7fffffff;
    if (v < -longint'(64'h80000000)) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned round_shift(longint unsigned m, int sh);
    return (m >> sh) + ((m >> (sh - 1)) & 64'd1);
  endfunction

  function automatic longint unsigned round_div(longint unsigned m, longint unsigned d);
    longint unsigned q, r;
    q = m / d;
    r = m % d;
    if (r >= d - r) q++;
    return q;
  endfunction

  // Advances the model by one input beat and returns the result it produces.
  function automatic filt_out_t filter_step(logic [1:0] act, logic signed [31:0] val,
                                            logic [31:0] stamp);
    filt_out_t r;
    logic [31:0] dt;
    longint sum, e;
    longint unsigned mag, area, grow, p, s, sq, lim, d, nv;
    bit neg;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_SAMPLE: begin
        if (!m_ready_init) r.status = ST_UNINIT;
        if (m_ready_init && m_have_prev) begin
          dt = stamp - m_prev_time;
          sum = longint'(m_prev_vel) + longint'(val);
          neg = sum < 0;
          mag = neg ? -sum : sum;
          area = round_shift(mag * longint'({32'd0, dt}), FRAC_BITS + 1);
          m_est = clamp_s32(longint'(m_est) + (neg ? -longint'(area) : longint'(area)));
          grow = round_shift(longint'({32'd0, dt}) * longint'({32'd0, m_pnoise}), FRAC_BITS);
          p = {32'd0, m_var} + grow;
          m_var = (p > 64'hffffffff) ? 32'hffffffff : p[31:0];
        end
        m_prev_vel = val;
        m_prev_time = stamp;
        m_have_prev = 1'b1;
      end
      ACT_MEASURE: begin
        if (!m_ready_init) begin
          r.status = ST_UNINIT;
        end else begin
          e = longint'(val) - longint'(m_est);
          neg = e < 0;
          mag = neg ? -e : e;
          p = {32'd0, m_var};
          s = p + {32'd0, m_mnoise};
          r.innov = clamp_s32(e);
          sq = mag * mag;
          lim = {48'd0, m_gate_sq} * s;
          if (m_gate_on && ((sq >> FRAC_BITS) > lim ||
              ((sq >> FRAC_BITS) == lim && sq[FRAC_BITS-1:0] != 0))) begin
            r.status = ST_REJECT;
          end else if (s != 0) begin
            d = round_div(p * mag, s);
            m_est = clamp_s32(longint'(m_est) + (neg ? -longint'(d) : longint'(d)));
            nv = round_div(p * {32'd0, m_mnoise}, s);
            m_var = (nv > 64'hffffffff) ? 32'hffffffff : nv[31:0];
          end
        end
      end
      ACT_INIT: begin
        m_est = val;
        m_var = m_init_var;
        m_ready_init = 1'b1;
      end
      default: begin
        m_ready_init = 1'b0;
        m_have_prev = 1'b0;
      end
    endcase
    r.est = m_est;
    r.varc = m_var;
    return r;
  endfunction

  // Every accepted input beat advances the model; a directed row with a typed
  // result queues that result instead of the computed one.
  always @(posedge clk) begin
    filt_out_t r;
    if (!rst && in_ch.valid && in_ch.ready) begin
      r = filter_step(in_ch.action, in_ch.value, in_ch.sample_time);
      pending_results.push_back(typed_beat ? typed_res : r);
    end
  end

  // Result side: random stalls and in-order comparison.
  always @(posedge clk) begin
    filt_out_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h/%h/%h/%0d", $time,
                   out_ch.estimate, out_ch.variance, out_ch.innovation, out_ch.status);
          errors++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_ch.estimate !== want.est) begin
            $display("%0t: estimate expected %h actual %h", $time, want.est, out_ch.estimate);
            errors++;
          end
          if (out_ch.variance !== want.varc) begin
            $display("%0t: variance expected %h actual %h", $time, want.varc, out_ch.variance);
            errors++;
          end
          if (out_ch.innovation !== want.innov) begin
            $display("%0t: innovation expected %h actual %h", $time, want.innov,
                     out_ch.innovation);
            errors++;
          end
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_ch.status);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: too long without a beat on either channel means the block hung.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("scalar_kalman_filter_with_gate regression: fail");
        $finish;
      end
    end
  end

  // Sends one beat. Valid is only lowered when the sender decides to idle, so a
  // back-to-back beat never sees valid dropped and raised in the same step.
  task automatic send_beat(logic [1:0] act, logic [31:0] val, logic [31:0] stamp,
                           bit typed, filt_out_t res);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.value <= val;
    in_ch.sample_time <= stamp;
    typed_beat <= typed;
    typed_res <= res;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Writes all five registers on consecutive edges, keeping the model in step.
  task automatic load_registers(logic [31:0] pn, logic [31:0] mn, logic [31:0] iv,
                                logic ge, logic [15:0] gs);
    logic [31:0] vals[5];
    logic [CFG_IDX_W-1:0] idx[5];
    vals = '{pn, mn, iv, {31'd0, ge}, {16'd0, gs}};
    idx = '{CFG_Q_NOISE, CFG_R_NOISE, CFG_INITIAL_VARIANCE,
            CFG_GATE_ENABLE, CFG_GATE_SQ};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_pnoise = pn;
    m_mnoise = mn;
    m_init_var = iv;
    m_gate_on = ge;
    m_gate_sq = gs;
  endtask

  // Registers may only change with the filter idle: drain, then let any
  // in-flight work finish.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Directed rows. Typed results are those readable at a glance: reset state,
  // inputs before initialization, the initialize loads and a sample with no earlier one.
  row_t rows[] = '{
    '{ACT_SAMPLE,  32'h7fffffff, 32'h00000000, 1, '{32'h0, 32'h0, 32'h0, ST_UNINIT}},
    '{ACT_MEASURE, 32'h80000000, 32'h00000000, 1, '{32'h0, 32'h0, 32'h0, ST_UNINIT}},
    '{ACT_INIT,    32'h7fffffff, 32'hffffffff, 1, '{32'h7fffffff, 32'h10000, 32'h0, ST_OK}},
    // Initialize keeps the earlier sample, so this one integrates and saturates.
    '{ACT_SAMPLE,  32'h7fffffff, 32'h00010000, 0, '0},
    '{ACT_MEASURE, 32'h80000000, 32'h00000000, 0, '0},
    '{ACT_RESET,   32'h00000000, 32'h00000000, 0, '0},
    '{ACT_MEASURE, 32'h00001234, 32'h00000000, 0, '0},
    '{ACT_INIT,    32'h80000000, 32'h00000000, 1, '{32'h80000000, 32'h10000, 32'h0, ST_OK}},
    '{ACT_SAMPLE,  32'h80000000, 32'hfffff000, 1, '{32'h80000000, 32'h10000, 32'h0, ST_OK}},
    // Timestamp wraps past zero here.
    '{ACT_SAMPLE,  32'h80000000, 32'h00001000, 0, '0},
    '{ACT_INIT,    32'h00000000, 32'h00000000, 1, '{32'h0, 32'h10000, 32'h0, ST_OK}},
    '{ACT_MEASURE, 32'h00000000, 32'h00000000, 0, '0},
    '{ACT_MEASURE, 32'h00050000, 32'h00000000, 0, '0},
    '{ACT_MEASURE, 32'h7fffffff, 32'h00000000, 0, '0},
    '{ACT_SAMPLE,  32'hffff0000, 32'h00020000, 0, '0},
    '{ACT_SAMPLE,  32'h00018000, 32'h00038000, 0, '0},
    '{ACT_SAMPLE,  32'h00000000, 32'hffffffff, 0, '0},
    '{ACT_MEASURE, 32'hfffe0000, 32'h00000000, 0, '0},
    '{ACT_RESET,   32'h00000000, 32'h00000000, 0, '0},
    '{ACT_SAMPLE,  32'h00010000, 32'h00000000, 0, '0}
  };

  initial begin
    logic [31:0] stamp, val;
    logic [1:0]  act;
    int          pick;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_SAMPLE;
    in_ch.value = '0;
    in_ch.sample_time = '0;
    // Model reset matches the register defaults loaded by reset.
    m_pnoise = 32'd0;
    m_mnoise = 32'h10000;
    m_init_var = 32'h10000;
    m_gate_on = 1'b0;
    m_gate_sq = 16'd25;
    m_est = '0;
    m_var = '0;
    m_ready_init = 1'b0;
    m_have_prev = 1'b0;
    m_prev_vel = '0;
    m_prev_time = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_beat(rows[i].action, rows[i].value, rows[i].stamp,
                                rows[i].typed, rows[i].res);

    // Random phases, each under its own register setting. Idling runs receiver
    // heavy, then sender heavy, then not at all.
    stamp = 32'd0;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: load_registers(32'h00001000, 32'h00010000, 32'h00010000, 1'b1, 16'd25);
        1: load_registers(32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 16'hffff);
        // Zero measurement noise and zero initial variance give a zero
        // innovation variance; a zero threshold rejects any nonzero innovation.
        2: load_registers(32'd0, 32'd0, 32'd0, 1'b1, 16'd0);
        3: load_registers(32'h00000100, 32'h00004000, 32'h00100000, 1'b0, 16'd9);
        4: load_registers($urandom, $urandom, $urandom, 1'($urandom_range(1)),
                          16'($urandom_range(65535)));
        default: load_registers(32'h00008000, 32'h00020000, 32'h0, 1'b1, 16'd4);
      endcase
      src_idle = (ph < 2) ? 38 : (ph < 4) ? 83 : 0;
      snk_idle = (ph < 2) ? 83 : (ph < 4) ? 38 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        act = (pick < 8) ? ACT_RESET : (pick < 20) ? ACT_INIT :
              (pick < 60) ? ACT_SAMPLE : ACT_MEASURE;
        // Mostly values close to the running estimate so measurements pass the
        // gate; some are full range.
        if ($urandom_range(99) < 15) val = $urandom;
        else if (act == ACT_MEASURE) val = m_est + $urandom_range(32'h40000) - 32'h20000;
        else val = $urandom_range(32'h80000) - 32'h40000;
        if ($urandom_range(99) < 10) stamp = $urandom;
        else stamp = stamp + $urandom_range(32'h40000);
        send_beat(act, val, stamp, 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("scalar_kalman_filter_with_gate regression: pass");
    end else begin
      $display("scalar_kalman_filter_with_gate regression: fail");
    end
    $finish;
  end
endmodule

/* scalar_kalman_filter_with_gate.f */
rtl/skf_pkg.sv
rtl/skf_ifs.sv
rtl/skf_datapath.sv
rtl/skf_ctrl.sv
rtl/scalar_kalman_filter_with_gate.sv
verif/tb.sv
